// File: hw/rtl/lts_pkg.sv
// lts_pkg: shared constants, control struct and divide-by-255 helper
// for the trilinear lookup sampler. No dependencies.
package lts_pkg;

    localparam int CHAN_W    = 16;
    localparam int CODE_W    = 8;
    localparam int WT_W      = 8;
    localparam int PROD_W    = 24;
    localparam int NUM_BANKS = 8;
    localparam int ACC_W     = 41;
    localparam int ENTRY_W   = 3 * CHAN_W;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    localparam logic [WT_W-1:0]  WT_FULL    = 8'd255;
    // (255^3 - 1) / 2, turns floor into round half up
    localparam logic [ACC_W-1:0] ROUND_BIAS = 41'd8290687;

    typedef struct packed {
        logic       sample;
        logic       wr_ok;
        logic [2:0] wr_bank;
    } t_item_ctl;

    // floor(x / 255) by shift-add estimate plus a small exact correction
    function automatic logic [ACC_W-1:0] div255(input logic [ACC_W-1:0] x);
        logic [ACC_W-1:0] q0;
        logic [ACC_W-1:0] r;
        logic [15:0]      rr;
        logic [15:0]      corr;
        q0   = (x >> 8) + (x >> 16) + (x >> 24) + (x >> 32) + (x >> 40);
        r    = x - ((q0 << 8) - q0);
        rr   = r[15:0];
        corr = (rr + (rr >> 8) + 16'd1) >> 8;
        return q0 + {{(ACC_W-16){1'b0}}, corr};
    endfunction

endpackage

// File: hw/rtl/lts_ram.sv
// lts_ram: generic single-write, single-read memory with registered read.
// No dependencies.
module lts_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule

// File: hw/rtl/lts_fifo.sv
// lts_fifo: small register queue between front and back of the sampler.
// No dependencies.
module lts_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic [PW-1:0]    n_wr, n_rd;
    logic [CW-1:0]    n_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end
endmodule

// File: hw/rtl/lts_front.sv
// lts_front: classifies items, splits write addresses and sample codes into
// bank addresses and corner weights. Depends on lts_pkg.
module lts_front import lts_pkg::*; #(
    parameter int GRID_SIDE = 33
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic                    i_valid,
    input  logic                    i_mode,
    input  logic [15:0]             i_entry_index,
    input  logic [ENTRY_W-1:0]      i_entry,
    input  logic [CODE_W-1:0]       i_pixel [3],
    output logic                    o_valid,
    output t_item_ctl               o_ctl,
    output logic [ENTRY_W-1:0]      o_wdata,
    output logic [NUM_BANKS-1:0][$clog2((GRID_SIDE/2+1)**3)-1:0] o_addr,
    output logic [NUM_BANKS-1:0][PROD_W-1:0] o_wt,
    output logic [NUM_BANKS-1:0]    o_mask
);
    localparam int HALF   = GRID_SIDE / 2 + 1;
    localparam int HH     = HALF * HALF;
    localparam int AW     = $clog2(HH * HALF);
    localparam int NN     = GRID_SIDE * GRID_SIDE;
    localparam int NE     = NN * GRID_SIDE;
    localparam int SIDE_M1 = GRID_SIDE - 1;
    localparam int CW     = $clog2(GRID_SIDE + 1);
    localparam int LCW    = $clog2(HALF);
    localparam int RW     = $clog2(NN);
    localparam int QW     = CODE_W + $clog2(GRID_SIDE);
    localparam logic [32:0] RECIP_NN = 33'(((64'd1 << 32) + NN - 1) / NN);
    localparam logic [32:0] RECIP_N  = 33'(((64'd1 << 32) + GRID_SIDE - 1) / GRID_SIDE);

    // stage 1
    logic               r1_v, r1_mode, r1_ok;
    logic [15:0]        r1_idx;
    logic [CW-1:0]      r1_z;
    logic [ENTRY_W-1:0] r1_data;
    logic [QW-1:0]      r1_q [3];
    // stage 2
    logic               r2_v, r2_mode, r2_ok;
    logic [RW-1:0]      r2_rem;
    logic [CW-1:0]      r2_z;
    logic [ENTRY_W-1:0] r2_data;
    logic [CW-1:0]      r2_lo [3];
    logic [WT_W-1:0]    r2_w [3];
    // stage 3
    logic               r3_v, r3_mode, r3_ok;
    logic [RW-1:0]      r3_rem;
    logic [CW-1:0]      r3_y, r3_z;
    logic [ENTRY_W-1:0] r3_data;
    logic [LCW-1:0]     r3_lc [3][2];
    logic               r3_mk [3][2];
    logic [WT_W-1:0]    r3_wz [2];
    logic [15:0]        r3_wxy [2][2];
    // stage 4
    logic               r4_v, r4_mode, r4_ok;
    logic [CW-1:0]      r4_x, r4_y, r4_z;
    logic [ENTRY_W-1:0] r4_data;
    logic [NUM_BANKS-1:0][AW-1:0]     r4_addr;
    logic [NUM_BANKS-1:0][PROD_W-1:0] r4_wt;
    logic [NUM_BANKS-1:0]             r4_mask;
    // stage 5
    logic               r5_v;
    t_item_ctl          r5_ctl;
    logic [ENTRY_W-1:0] r5_data;
    logic [NUM_BANKS-1:0][AW-1:0]     r5_addr;
    logic [NUM_BANKS-1:0][PROD_W-1:0] r5_wt;
    logic [NUM_BANKS-1:0]             r5_mask;

    logic [48:0]        zprod;
    logic [45:0]        yprod;
    logic [15:0]        qx, lo16;
    logic [CW-1:0]      c;
    logic               sel;
    logic [WT_W-1:0]    wsel [3][2];
    logic [CW-1:0]      n2_lo [3];
    logic [WT_W-1:0]    n2_w [3];
    logic [LCW-1:0]     n3_lc [3][2];
    logic               n3_mk [3][2];
    logic [NUM_BANKS-1:0][AW-1:0]     n4_addr;
    logic [NUM_BANKS-1:0][PROD_W-1:0] n4_wt;
    logic [NUM_BANKS-1:0]             n4_mask;
    logic [AW-1:0]      n5_waddr;

    assign zprod = {33'b0, i_entry_index} * {16'b0, RECIP_NN};
    assign yprod = 46'(r2_rem) * 46'(RECIP_N);

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            qx       = 16'(r1_q[a]);
            lo16     = (qx + (qx >> 8) + 16'd1) >> 8;
            n2_lo[a] = lo16[CW-1:0];
            n2_w[a]  = 8'(qx - lo16 * 16'd255);
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int p = 0; p < 2; p++) begin
                sel         = (r2_lo[a][0] == 1'(p));
                c           = sel ? r2_lo[a] : r2_lo[a] + 1'b1;
                wsel[a][p]  = sel ? WT_FULL - r2_w[a] : r2_w[a];
                n3_mk[a][p] = (c > CW'(SIDE_M1));
                n3_lc[a][p] = LCW'(c >> 1);
            end
        end
    end

    always_comb begin
        for (int b = 0; b < NUM_BANKS; b++) begin
            n4_addr[b] = AW'(32'(r3_lc[0][b%2]) + 32'(r3_lc[1][(b/2)%2]) * HALF
                          + 32'(r3_lc[2][b/4]) * HH);
            n4_wt[b]   = PROD_W'(r3_wxy[b%2][(b/2)%2]) * PROD_W'(r3_wz[b/4]);
            n4_mask[b] = r3_mk[0][b%2] | r3_mk[1][(b/2)%2] | r3_mk[2][b/4];
        end
    end

    assign n5_waddr = AW'(32'(r4_x >> 1) + 32'(r4_y >> 1) * HALF + 32'(r4_z >> 1) * HH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (i_adv) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
        if (i_adv) begin
            r1_mode <= i_mode;
            r1_ok   <= (32'(i_entry_index) < NE);
            r1_idx  <= i_entry_index;
            r1_z    <= zprod[32 +: CW];
            r1_data <= i_entry;
            for (int a = 0; a < 3; a++) begin
                r1_q[a] <= QW'(i_pixel[a]) * QW'(SIDE_M1);
            end

            r2_mode <= r1_mode;
            r2_ok   <= r1_ok;
            r2_rem  <= RW'(32'(r1_idx) - 32'(r1_z) * NN);
            r2_z    <= r1_z;
            r2_data <= r1_data;
            r2_lo   <= n2_lo;
            r2_w    <= n2_w;

            r3_mode <= r2_mode;
            r3_ok   <= r2_ok;
            r3_rem  <= r2_rem;
            r3_y    <= yprod[32 +: CW];
            r3_z    <= r2_z;
            r3_data <= r2_data;
            r3_lc   <= n3_lc;
            r3_mk   <= n3_mk;
            r3_wz   <= wsel[2];
            for (int px = 0; px < 2; px++) begin
                for (int py = 0; py < 2; py++) begin
                    r3_wxy[px][py] <= 16'(wsel[0][px]) * 16'(wsel[1][py]);
                end
            end

            r4_mode <= r3_mode;
            r4_ok   <= r3_ok;
            r4_x    <= CW'(32'(r3_rem) - 32'(r3_y) * GRID_SIDE);
            r4_y    <= r3_y;
            r4_z    <= r3_z;
            r4_data <= r3_data;
            r4_addr <= n4_addr;
            r4_wt   <= n4_wt;
            r4_mask <= n4_mask;

            r5_ctl.sample  <= (r4_mode == MODE_SAMPLE);
            r5_ctl.wr_ok   <= r4_ok;
            r5_ctl.wr_bank <= {r4_z[0], r4_y[0], r4_x[0]};
            r5_data        <= r4_data;
            r5_wt          <= r4_wt;
            r5_mask        <= r4_mask;
            if (r4_mode == MODE_SAMPLE) begin
                r5_addr <= r4_addr;
            end else begin
                r5_addr <= {NUM_BANKS{n5_waddr}};
            end
        end
    end

    assign o_valid = r5_v;
    assign o_ctl   = r5_ctl;
    assign o_wdata = r5_data;
    assign o_addr  = r5_addr;
    assign o_wt    = r5_wt;
    assign o_mask  = r5_mask;
endmodule

// File: hw/rtl/lts_back.sv
// lts_back: eight parity banks of the grid, corner products, sum and rounding.
// Depends on lts_pkg and lts_ram.
module lts_back import lts_pkg::*; #(
    parameter int GRID_SIDE = 33
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  logic                    i_valid,
    input  t_item_ctl               i_ctl,
    input  logic [ENTRY_W-1:0]      i_wdata,
    input  logic [NUM_BANKS-1:0][$clog2((GRID_SIDE/2+1)**3)-1:0] i_addr,
    input  logic [NUM_BANKS-1:0][PROD_W-1:0] i_wt,
    input  logic [NUM_BANKS-1:0]    i_mask,
    output logic                    o_valid,
    output logic [CHAN_W-1:0]       o_chan [3]
);
    localparam int HALF  = GRID_SIDE / 2 + 1;
    localparam int DEPTH = HALF * HALF * HALF;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = CHAN_W + PROD_W;

    logic [ENTRY_W-1:0] rdata [NUM_BANKS];

    logic                    r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v;
    logic [NUM_BANKS-1:0][PROD_W-1:0] r1_wt;
    logic [NUM_BANKS-1:0]    r1_mask;
    logic [PW-1:0]           r2_prod [3][NUM_BANKS];
    logic [ACC_W-1:0]        r3_sum [3][4];
    logic [ACC_W-1:0]        r4_t [3];
    logic [32:0]             r5_q [3];
    logic [24:0]             r6_q [3];
    logic [16:0]             r7_q [3];
    logic [ACC_W-1:0]        d5 [3], d6 [3], d7 [3];

    generate
        for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
            logic we;
            assign we = i_adv && i_valid && !i_ctl.sample && i_ctl.wr_ok
                        && (i_ctl.wr_bank == 3'(b));
            lts_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
                .i_clk   (i_clk),
                .i_we    (we),
                .i_waddr (i_addr[b][AW-1:0]),
                .i_wdata (i_wdata),
                .i_re    (i_adv),
                .i_raddr (i_addr[b][AW-1:0]),
                .o_rdata (rdata[b])
            );
        end
    endgenerate

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            d5[ch] = div255(r4_t[ch]);
            d6[ch] = div255(ACC_W'(r5_q[ch]));
            d7[ch] = div255(ACC_W'(r6_q[ch]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (i_adv) begin
            r1_v <= i_valid && i_ctl.sample;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
        end
        if (i_adv) begin
            r1_wt   <= i_wt;
            r1_mask <= i_mask;
            for (int ch = 0; ch < 3; ch++) begin
                // red sits in the top lane of an entry
                for (int b = 0; b < NUM_BANKS; b++) begin
                    r2_prod[ch][b] <= r1_mask[b] ? '0 :
                        PW'(rdata[b][(2-ch)*CHAN_W +: CHAN_W]) * PW'(r1_wt[b]);
                end
                for (int s = 0; s < 4; s++) begin
                    r3_sum[ch][s] <= ACC_W'(r2_prod[ch][2*s]) + ACC_W'(r2_prod[ch][2*s+1]);
                end
                r4_t[ch] <= r3_sum[ch][0] + r3_sum[ch][1] + r3_sum[ch][2]
                            + r3_sum[ch][3] + ROUND_BIAS;
                r5_q[ch] <= d5[ch][32:0];
                r6_q[ch] <= d6[ch][24:0];
                r7_q[ch] <= d7[ch][16:0];
            end
        end
    end

    assign o_valid = r7_v;
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            o_chan[ch] = r7_q[ch][16] ? {CHAN_W{1'b1}} : r7_q[ch][15:0];
        end
    end
endmodule

// File: hw/rtl/lut_trilinear_sampler.sv
// Trilinear 3D colour lookup sampler, one pixel per clock while nothing stalls. Write items load
// a GRID_SIDE^3 grid of 48-bit entries; sample items map an 8-bit RGB pixel to
// a 16-bit-per-channel colour, rounded half up. Depends on lts_pkg, lts_front,
// lts_fifo, lts_back and lts_ram.
// Throughput is one item per cycle while nothing stalls: the grid is split into
// eight banks by the parity of x, y and z, so the eight corners of a cell are
// read in the same cycle, one from each bank. A sample result passes the 5 front
// stages, the queue and the 7 back stages in that order; write items give no
// result and take effect for every later sample. Reads of grid entries never
// written return arbitrary values. full rises only while the front queue is
// backed up by a stalled result side.
module lut_trilinear_sampler import lts_pkg::*; #(
    parameter int GRID_SIDE = 33
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_mode,
    input  logic [15:0] i_entry_index,
    input  logic [15:0] i_entry_red,
    input  logic [15:0] i_entry_green,
    input  logic [15:0] i_entry_blue,
    input  logic [7:0]  i_pixel_red,
    input  logic [7:0]  i_pixel_green,
    input  logic [7:0]  i_pixel_blue,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_out_red,
    output logic [15:0] o_out_green,
    output logic [15:0] o_out_blue
);
    localparam int AW = $clog2((GRID_SIDE / 2 + 1) ** 3);
    localparam int QD = 4;
    localparam int IW = $bits(t_item_ctl) + ENTRY_W + NUM_BANKS * (AW + PROD_W + 1);

    logic f_adv, f_valid, b_adv, b_valid;
    logic q_push, q_pop, q_full, q_empty;
    t_item_ctl f_ctl, h_ctl;
    logic [ENTRY_W-1:0] f_wdata, h_wdata;
    logic [NUM_BANKS-1:0][AW-1:0]     f_addr, h_addr;
    logic [NUM_BANKS-1:0][PROD_W-1:0] f_wt, h_wt;
    logic [NUM_BANKS-1:0]             f_mask, h_mask;
    logic [IW-1:0] q_in, q_out;
    logic [CODE_W-1:0] pix [3];
    logic [CHAN_W-1:0] chan [3];

    assign f_adv  = !f_valid || !q_full;
    assign full   = !f_adv;
    assign q_push = f_valid && f_adv;
    assign b_adv  = !b_valid || pop;
    assign q_pop  = b_adv && !q_empty;
    assign empty  = !b_valid;

    assign pix[0] = i_pixel_red;
    assign pix[1] = i_pixel_green;
    assign pix[2] = i_pixel_blue;

    lts_front #(.GRID_SIDE(GRID_SIDE)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (f_adv),
        .i_valid       (push),
        .i_mode        (i_mode),
        .i_entry_index (i_entry_index),
        .i_entry       ({i_entry_red, i_entry_green, i_entry_blue}),
        .i_pixel       (pix),
        .o_valid       (f_valid),
        .o_ctl         (f_ctl),
        .o_wdata       (f_wdata),
        .o_addr        (f_addr),
        .o_wt          (f_wt),
        .o_mask        (f_mask)
    );

    assign q_in = {f_ctl, f_wdata, f_addr, f_wt, f_mask};
    assign {h_ctl, h_wdata, h_addr, h_wt, h_mask} = q_out;

    lts_fifo #(.WIDTH(IW), .DEPTH(QD)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    lts_back #(.GRID_SIDE(GRID_SIDE)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (b_adv),
        .i_valid (!q_empty),
        .i_ctl   (h_ctl),
        .i_wdata (h_wdata),
        .i_addr  (h_addr),
        .i_wt    (h_wt),
        .i_mask  (h_mask),
        .o_valid (b_valid),
        .o_chan  (chan)
    );

    assign o_out_red   = chan[0];
    assign o_out_green = chan[1];
    assign o_out_blue  = chan[2];

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_push && q_full && !q_pop))
        else $error("queue written while full");

    a_queue_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue read while empty");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result pending right after reset");
endmodule

// File: bench/lts_checker.sv
// lts_checker: watches the item and result channels of the trilinear sampler,
// keeps its own copy of the grid, predicts each sample and compares. Uses lts_pkg.
`timescale 1ns / 1ps
module lts_checker import lts_pkg::*; #(
    parameter int GRID_SIDE = 33
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic        i_mode,
    input  logic [15:0] i_entry_index,
    input  logic [15:0] i_entry_red,
    input  logic [15:0] i_entry_green,
    input  logic [15:0] i_entry_blue,
    input  logic [7:0]  i_pixel_red,
    input  logic [7:0]  i_pixel_green,
    input  logic [7:0]  i_pixel_blue,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [15:0] i_out_red,
    input  logic [15:0] i_out_green,
    input  logic [15:0] i_out_blue,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);
    localparam int ENTRIES = GRID_SIDE * GRID_SIDE * GRID_SIDE;
    localparam longint DENOM = 64'd16581375;

    logic [15:0] grid_copy [ENTRIES][3];
    logic [47:0] colors_due [$];

    initial begin
        o_errors  = 0;
        o_checked = 0;
        o_pending = 0;
    end

    // lower corner, upper corner and upper weight along one axis
    function automatic void split_axis(input logic [7:0] code, output int lo,
                                       output int hi, output longint wt);
        int q;
        q  = int'(code) * (GRID_SIDE - 1);
        lo = q / 255;
        hi = (lo + 1 > GRID_SIDE - 1) ? GRID_SIDE - 1 : lo + 1;
        wt = q % 255;
    endfunction

    function automatic logic [47:0] interpolate_color(input logic [7:0] pr,
                                                      input logic [7:0] pg,
                                                      input logic [7:0] pb);
        int xs[2], ys[2], zs[2];
        longint wx[2], wy[2], wz[2];
        longint acc[3];
        longint w, r;
        int addr;
        logic [47:0] res;
        split_axis(pr, xs[0], xs[1], wx[1]);
        split_axis(pg, ys[0], ys[1], wy[1]);
        split_axis(pb, zs[0], zs[1], wz[1]);
        wx[0] = 255 - wx[1];
        wy[0] = 255 - wy[1];
        wz[0] = 255 - wz[1];
        for (int c = 0; c < 3; c++) acc[c] = 0;
        for (int k = 0; k < 2; k++)
            for (int j = 0; j < 2; j++)
                for (int i = 0; i < 2; i++) begin
                    addr = xs[i] + ys[j] * GRID_SIDE + zs[k] * GRID_SIDE * GRID_SIDE;
                    w = wx[i] * wy[j] * wz[k];
                    for (int c = 0; c < 3; c++)
                        acc[c] += longint'(grid_copy[addr][c]) * w;
                end
        for (int c = 0; c < 3; c++) begin
            r = (2 * acc[c] + DENOM) / (2 * DENOM);
            if (r > 65535) r = 65535;
            res[47 - 16*c -: 16] = r[15:0];
        end
        return res;
    endfunction

    task automatic report(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_push && !i_full) begin
            if (i_mode == MODE_WRITE) begin
                if (int'(i_entry_index) < ENTRIES) begin
                    grid_copy[i_entry_index][0] = i_entry_red;
                    grid_copy[i_entry_index][1] = i_entry_green;
                    grid_copy[i_entry_index][2] = i_entry_blue;
                end
            end else begin
                colors_due.insert(colors_due.size(),
                                  interpolate_color(i_pixel_red, i_pixel_green,
                                                    i_pixel_blue));
            end
        end
        if (i_rst_n && i_pop && !i_empty) begin
            if (colors_due.size() == 0) begin
                report($sformatf("unexpected result %0d %0d %0d",
                                 i_out_red, i_out_green, i_out_blue));
            end else begin
                logic [47:0] want;
                want = colors_due.pop_front();
                o_checked++;
                if (i_out_red != want[47:32])
                    report($sformatf("red got %0d expected %0d", i_out_red, want[47:32]));
                if (i_out_green != want[31:16])
                    report($sformatf("green got %0d expected %0d", i_out_green,
                                     want[31:16]));
                if (i_out_blue != want[15:0])
                    report($sformatf("blue got %0d expected %0d", i_out_blue, want[15:0]));
            end
        end
        o_pending = colors_due.size();
    end
endmodule

// File: bench/tb.sv
// tb: loads the grid entries whose coordinates all lie in the three lowest or
// highest planes, then drives directed and random samples and writes into
// lut_trilinear_sampler with bursty input and stalling output. Uses lts_checker.
`timescale 1ns / 1ps
module tb import lts_pkg::*;;
    localparam int SIDE      = 33;
    localparam int ENTRIES   = SIDE * SIDE * SIDE;
    localparam int LIMIT     = 1000000;
    localparam int N_RANDOM  = 180;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_mode = MODE_WRITE;
    logic [15:0] i_entry_index = '0;
    logic [15:0] i_entry_red = '0;
    logic [15:0] i_entry_green = '0;
    logic [15:0] i_entry_blue = '0;
    logic [7:0]  i_pixel_red = '0;
    logic [7:0]  i_pixel_green = '0;
    logic [7:0]  i_pixel_blue = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [15:0] o_out_red, o_out_green, o_out_blue;
    int          errors, pending, checked;
    int          cycles = 0;
    int          burst_left = 0;
    int          n_writes = 0;
    int          n_samples = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    lut_trilinear_sampler #(.GRID_SIDE(SIDE)) DUT (
        .i_clk, .i_rst_n, .push, .full, .i_mode, .i_entry_index, .i_entry_red,
        .i_entry_green, .i_entry_blue, .i_pixel_red, .i_pixel_green, .i_pixel_blue,
        .empty, .pop, .o_out_red, .o_out_green, .o_out_blue
    );

    lts_checker #(.GRID_SIDE(SIDE)) u_checker (
        .i_clk, .i_rst_n, .i_push(push), .i_full(full), .i_mode, .i_entry_index,
        .i_entry_red, .i_entry_green, .i_entry_blue, .i_pixel_red, .i_pixel_green,
        .i_pixel_blue, .i_empty(empty), .i_pop(pop), .i_out_red(o_out_red),
        .i_out_green(o_out_green), .i_out_blue(o_out_blue),
        .o_errors(errors), .o_pending(pending), .o_checked(checked)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb failed");
            $finish;
        end
    end

    // receiver: free-running, light and heavy stall stretches
    int stall_kind = 0;
    int stall_left = 0;
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_kind = $urandom_range(0, 2);
            stall_left = $urandom_range(10, 200);
        end
        stall_left--;
        case (stall_kind)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 3) != 0);
            default: pop <= ($urandom_range(0, 4) == 0);
        endcase
    end

    function automatic logic [15:0] rand_chan();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // codes stay where the corners fall in the three lowest or highest planes
    function automatic logic [7:0] rand_code();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hff;
            2, 3, 4, 5: return 8'($urandom_range(0, 15));
            default: return 8'($urandom_range(240, 255));
        endcase
    endfunction

    // grid coordinate of the k-th loaded plane: 0, 1, 2 and the top three
    function automatic int axis_at(input int k);
        return (k < 3) ? k : SIDE - 6 + k;
    endfunction

    // called at a falling edge; returns at a falling edge after acceptance
    task automatic send_item(input logic mode, input logic [15:0] idx,
                             input logic [15:0] r, input logic [15:0] g,
                             input logic [15:0] b, input logic [7:0] pr,
                             input logic [7:0] pg, input logic [7:0] pb);
        int   gap;
        logic was_full;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        push          <= 1'b1;
        i_mode        <= mode;
        i_entry_index <= idx;
        i_entry_red   <= r;
        i_entry_green <= g;
        i_entry_blue  <= b;
        i_pixel_red   <= pr;
        i_pixel_green <= pg;
        i_pixel_blue  <= pb;
        // full only moves on rising edges, so its value here holds at the next one
        forever begin
            was_full = full;
            @(posedge i_clk);
            if (!was_full) break;
            @(negedge i_clk);
        end
        @(negedge i_clk);
        if (mode == MODE_WRITE) n_writes++;
        else n_samples++;
    endtask

    task automatic write_entry(input logic [15:0] idx, input logic [15:0] r,
                               input logic [15:0] g, input logic [15:0] b);
        send_item(MODE_WRITE, idx, r, g, b, rand_code(), rand_code(), rand_code());
    endtask

    task automatic sample_pixel(input logic [7:0] pr, input logic [7:0] pg,
                                input logic [7:0] pb);
        send_item(MODE_SAMPLE, 16'($urandom), rand_chan(), rand_chan(), rand_chan(),
                  pr, pg, pb);
    endtask

    task automatic drain();
        push <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        logic [15:0] idx;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every entry a sample can reach gets written before any sample
        for (int kz = 0; kz < 6; kz++)
            for (int ky = 0; ky < 6; ky++)
                for (int kx = 0; kx < 6; kx++)
                    write_entry(16'(axis_at(kx) + axis_at(ky) * SIDE
                                    + axis_at(kz) * SIDE * SIDE),
                                rand_chan(), rand_chan(), rand_chan());

        // directed: corners, mixed planes, clamped top cell
        sample_pixel(8'h00, 8'h00, 8'h00);
        sample_pixel(8'hff, 8'hff, 8'hff);
        sample_pixel(8'hff, 8'h00, 8'h00);
        sample_pixel(8'h00, 8'hff, 8'h00);
        sample_pixel(8'h00, 8'h00, 8'hff);
        sample_pixel(8'h0f, 8'hf0, 8'h08);
        sample_pixel(8'hfe, 8'hfe, 8'hfe);
        // saturate the top cell, then sample it
        for (int z = SIDE - 2; z < SIDE; z++)
            for (int y = SIDE - 2; y < SIDE; y++)
                for (int x = SIDE - 2; x < SIDE; x++)
                    write_entry(16'(x + y*SIDE + z*SIDE*SIDE), 16'hffff, 16'hffff, 16'hffff);
        sample_pixel(8'hfe, 8'hfd, 8'hff);
        sample_pixel(8'hff, 8'hff, 8'hff);
        // zero bottom cell
        for (int z = 0; z < 2; z++)
            for (int y = 0; y < 2; y++)
                for (int x = 0; x < 2; x++)
                    write_entry(16'(x + y*SIDE + z*SIDE*SIDE), 16'h0000, 16'h0000, 16'h0000);
        sample_pixel(8'h05, 8'h03, 8'h07);
        // out of range writes must leave the grid alone
        write_entry(16'(ENTRIES), 16'h1234, 16'h5678, 16'h9abc);
        write_entry(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        write_entry(16'(ENTRIES - 1), 16'h0000, 16'hffff, 16'h8000);
        sample_pixel(8'hff, 8'hff, 8'hff);
        sample_pixel(8'h00, 8'h00, 8'h00);

        drain();

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) drain();
            if ($urandom_range(0, 9) < 3) begin
                idx = ($urandom_range(0, 4) == 0)
                    ? 16'($urandom)
                    : 16'(axis_at($urandom_range(0, 5))
                          + axis_at($urandom_range(0, 5)) * SIDE
                          + axis_at($urandom_range(0, 5)) * SIDE * SIDE);
                write_entry(idx, rand_chan(), rand_chan(), rand_chan());
            end else begin
                sample_pixel(rand_code(), rand_code(), rand_code());
            end
        end

        drain();
        repeat (30) @(negedge i_clk);
        $display("covered %0d writes and %0d samples, %0d results compared",
                 n_writes, n_samples, checked);
        if (errors == 0 && pending == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/lts_pkg.sv
hw/rtl/lts_ram.sv
hw/rtl/lts_fifo.sv
hw/rtl/lts_front.sv
hw/rtl/lts_back.sv
hw/rtl/lut_trilinear_sampler.sv
bench/lts_checker.sv
bench/tb.sv
